// ===== design/round_robin_downlink_scheduler_defines.svh =====
// assertion macros shared by the scheduler checkers
// depends on nothing; expects clk and rst in the scope of use
`ifndef ROUND_ROBIN_DOWNLINK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_DOWNLINK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrds_pkg.sv =====
// shared types and constants of the round-robin downlink scheduler
// no dependencies
package rrds_pkg;

  localparam int LINK_IDX_W = 2;
  localparam int MASK_W     = 4;
  localparam int NUM_W      = 32;
  localparam int BACKLOG_W  = 9;

  typedef struct packed {
    logic [MASK_W-1:0] arrival_mask;
    logic [MASK_W-1:0] channel_good_mask;
  } slot_item_t;

  typedef struct packed {
    logic                  served;
    logic [LINK_IDX_W-1:0] served_link;
    logic [NUM_W-1:0]      served_packet_id;
    logic [NUM_W-1:0]      served_gen_slot;
    logic [BACKLOG_W-1:0]  total_backlog;
    logic [MASK_W-1:0]     dropped_mask;
  } result_item_t;

  // one entry of the packet store
  typedef struct packed {
    logic [NUM_W-1:0] id;
    logic [NUM_W-1:0] gen;
  } store_word_t;

  // outcome of the round-robin scan
  typedef struct packed {
    logic                  found;
    logic [LINK_IDX_W-1:0] link;
  } pick_t;

endpackage

// ===== design/rrds_pkt_store.sv =====
// packet store: single-port-write, single-port-read synchronous ram
// depends on rrds_pkg for the entry type
module rrds_pkt_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  rrds_pkg::store_word_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output rrds_pkg::store_word_t rd_data
);
  import rrds_pkg::*;

  store_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rrds_rr_pick.sv =====
// round-robin scan: first ready link after the last one served
// depends on rrds_pkg for the pick type
module rrds_rr_pick #(
  parameter int NUM_LINKS = 4
) (
  input  logic [NUM_LINKS-1:0]            nonempty,
  input  logic [NUM_LINKS-1:0]            good,
  input  logic [rrds_pkg::LINK_IDX_W-1:0] last,
  output rrds_pkg::pick_t                 pick
);
  import rrds_pkg::*;

  always_comb begin
    logic [LINK_IDX_W:0]   sum;
    logic [LINK_IDX_W-1:0] cand;
    pick = '0;
    for (int off = 1; off <= NUM_LINKS; off++) begin
      sum = {1'b0, last} + (LINK_IDX_W + 1)'(off);
      if (sum >= (LINK_IDX_W + 1)'(NUM_LINKS)) begin
        sum = sum - (LINK_IDX_W + 1)'(NUM_LINKS);
      end
      cand = sum[LINK_IDX_W-1:0];
      if (!pick.found && nonempty[cand] && good[cand]) begin
        pick.found = 1'b1;
        pick.link  = cand;
      end
    end
  end

endmodule

// ===== design/round_robin_downlink_scheduler.sv =====
// round-robin downlink scheduler: top level with queue state and slot sequencer
// depends on rrds_pkg, rrds_pkt_store and rrds_rr_pick
//
// usage
//   slot channel (slot_valid/slot_ready/slot): one transaction per time slot, carrying
//   the arrival mask and the channel-good mask. result channel (result_valid/
//   result_ready/result): exactly one transaction per slot, in slot order.
//   each slot first writes its arrivals into the packet store one link per cycle,
//   then scans round-robin for a non-empty link with a good channel, reads its head
//   packet and returns it with the backlog and the drop mask.
//   a slot is taken only in the idle state: a new slot waits until the current one has
//   left the response state; the store's single write port takes one arrival per cycle.
//   a new slot is taken while the previous result still waits; if the receiver
//   stalls, the finished slot holds in the read stage until the result register frees.
//   reset clears every queue and the round-robin pointer and sets the packet number
//   and slot counter to one; the packet store itself is not cleared.
module round_robin_downlink_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int NUM_LINKS   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   slot_valid,
  output logic                   slot_ready,
  input  rrds_pkg::slot_item_t   slot,
  output logic                   result_valid,
  input  logic                   result_ready,
  output rrds_pkg::result_item_t result
);
  import rrds_pkg::*;

  localparam int LK_W   = $clog2(NUM_LINKS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE  = NUM_LINKS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(STORE);
  localparam int SUM_W  = (CNT_W + 2 > BACKLOG_W) ? CNT_W + 2 : BACKLOG_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ENQ  = 4'b0010,
    ST_PICK = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t                state;
  logic [MASK_W-1:0]     arrivals;
  logic [MASK_W-1:0]     goods;
  logic [MASK_W-1:0]     dropped;
  logic [LK_W-1:0]       link_cnt;
  logic [PTR_W-1:0]      head [NUM_LINKS];
  logic [PTR_W-1:0]      tail [NUM_LINKS];
  logic [CNT_W-1:0]      count [NUM_LINKS];
  logic [LINK_IDX_W-1:0] rr;
  logic [NUM_W-1:0]      next_pkt;
  logic [NUM_W-1:0]      slot_cnt;
  logic                  hit;
  logic [LINK_IDX_W-1:0] hit_link;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  store_word_t           wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  store_word_t           rd_data;
  logic [NUM_LINKS-1:0]  nonempty;
  pick_t                 pick;
  logic [LK_W-1:0]       pick_idx;
  logic                  full_k;
  logic                  out_free;
  logic [BACKLOG_W-1:0]  backlog;

  assign slot_ready = (state == ST_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign full_k     = (count[link_cnt] == CNT_W'(QUEUE_DEPTH));
  assign pick_idx   = pick.link[LK_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_LINKS; i++) begin
      nonempty[i] = (count[i] != '0);
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      sum = sum + SUM_W'(count[i]);
    end
    backlog = sum[BACKLOG_W-1:0];
  end

  assign wr_en   = (state == ST_ENQ) && arrivals[link_cnt] && !full_k;
  assign wr_addr = ADDR_W'(link_cnt) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[link_cnt]);
  assign wr_data = '{id: next_pkt, gen: slot_cnt};
  assign rd_en   = (state == ST_PICK) && pick.found;
  assign rd_addr = ADDR_W'(pick_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[pick_idx]);

  rrds_pkt_store #(
    .DEPTH  (STORE),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrds_rr_pick #(
    .NUM_LINKS (NUM_LINKS)
  ) u_pick (
    .nonempty (nonempty),
    .good     (goods[NUM_LINKS-1:0]),
    .last     (rr),
    .pick     (pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      rr           <= '0;
      next_pkt     <= NUM_W'(1);
      slot_cnt     <= NUM_W'(1);
      link_cnt     <= '0;
      for (int i = 0; i < NUM_LINKS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (slot_valid) begin
            arrivals <= slot.arrival_mask;
            goods    <= slot.channel_good_mask;
            dropped  <= '0;
            link_cnt <= '0;
            state    <= ST_ENQ;
          end
        end
        ST_ENQ: begin
          if (arrivals[link_cnt]) begin
            if (full_k) begin
              dropped[link_cnt] <= 1'b1;
            end else begin
              tail[link_cnt]  <= (tail[link_cnt] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : tail[link_cnt] + 1'b1;
              count[link_cnt] <= count[link_cnt] + 1'b1;
              next_pkt        <= next_pkt + 1'b1;
            end
          end
          if (link_cnt == LK_W'(NUM_LINKS - 1)) begin
            state <= ST_PICK;
          end else begin
            link_cnt <= link_cnt + 1'b1;
          end
        end
        ST_PICK: begin
          hit      <= pick.found;
          hit_link <= pick.link;
          if (pick.found) begin
            head[pick_idx]  <= (head[pick_idx] == PTR_W'(QUEUE_DEPTH - 1)) ?
                               '0 : head[pick_idx] + 1'b1;
            count[pick_idx] <= count[pick_idx] - 1'b1;
            rr              <= pick.link;
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            result_valid            <= 1'b1;
            result.served           <= hit;
            result.served_link      <= hit ? hit_link : '0;
            result.served_packet_id <= hit ? rd_data.id : '0;
            result.served_gen_slot  <= hit ? rd_data.gen : '0;
            result.total_backlog    <= backlog;
            result.dropped_mask     <= dropped;
            slot_cnt                <= slot_cnt + 1'b1;
            state                   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/rrds_checker.sv =====
// port-level checks for the round-robin downlink scheduler, bound to the top level
// depends on rrds_pkg and round_robin_downlink_scheduler_defines.svh
`include "round_robin_downlink_scheduler_defines.svh"

module rrds_checker #(
  parameter int NUM_LINKS = 4
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   slot_valid,
  input logic                   slot_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input rrds_pkg::result_item_t result
);
  import rrds_pkg::*;

  logic slot_acc;
  assign slot_acc = slot_valid && slot_ready;

  // a slot runs through the enqueue, pick and response states, so no two transactions in a row
  `RRDS_ASSERT_NEXT(a_no_back_to_back, slot_acc, !slot_ready, "slot taken in consecutive cycles")

  // an idle slot reports all-zero service fields
  `RRDS_ASSERT_NOW(a_idle_zero, result_valid && !result.served, (result.served_link == '0) && (result.served_packet_id == '0) && (result.served_gen_slot == '0), "unserved slot with non-zero fields")

  // only existing links are served or dropped
  `RRDS_ASSERT_NOW(a_link_range, result_valid && result.served, 32'(result.served_link) < NUM_LINKS, "served link out of range")
  `RRDS_ASSERT_NOW(a_drop_range, result_valid, (32'(result.dropped_mask) >> NUM_LINKS) == 0, "drop on a missing link")

  // stalled result holds
  `RRDS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

endmodule

bind round_robin_downlink_scheduler rrds_checker #(
  .NUM_LINKS (NUM_LINKS)
) u_rrds_checker (
  .clk          (clk),
  .rst          (rst),
  .slot_valid   (slot_valid),
  .slot_ready   (slot_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
